>>> rtl/core/outlined_number_tile_renderer_top_defines.svh
// Assertion macros used by the renderer back end
`ifndef OUTLINED_NUMBER_TILE_RENDERER_TOP_DEFINES_SVH
`define OUTLINED_NUMBER_TILE_RENDERER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define ONR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define ONR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/onr_pkg.sv
// Shared types, constants and glyph tables of the outlined number tile renderer
package onr_pkg;

    localparam int S_TDATA_W  = 16;
    localparam int KIND_W     = 3;
    localparam int TILE_W     = 2;
    localparam int ROW_W      = 3;
    localparam int WORD_W     = 32;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - WORD_W - ROW_W - TILE_W;

    localparam int AMT_W      = 10;
    localparam logic [AMT_W-1:0] AMOUNT_MAX = 10'd999;

    localparam int GLYPH_W    = 5;
    localparam int MAX_GLYPHS = 5;
    localparam int COUNT_W    = 3;
    localparam int GLYPH_ROWS = 5;
    localparam int GLYPH_TOP  = 2;
    localparam int STRIP_COLS = 32;
    localparam int ROWS       = 8;
    localparam int IDX_W      = 5;

    localparam int ONR_QUEUE_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DAMAGE  = 3'd0,
        KIND_HEAL    = 3'd1,
        KIND_MISS    = 3'd2,
        KIND_IMMUNE  = 3'd3,
        KIND_DEFENSE = 3'd4
    } kind_t;

    typedef logic [GLYPH_W-1:0] glyph_t;

    // Letter and sign codes; digits use codes 0 to 9
    localparam glyph_t G_F    = 5'd10;
    localparam glyph_t G_A    = 5'd11;
    localparam glyph_t G_L    = 5'd12;
    localparam glyph_t G_O    = 5'd13;
    localparam glyph_t G_N    = 5'd14;
    localparam glyph_t G_D    = 5'd15;
    localparam glyph_t G_E    = 5'd16;
    localparam glyph_t G_DASH = 5'd17;
    localparam glyph_t G_PLUS = 5'd18;

    // Classified item: glyph codes left to right and how many are used
    typedef struct packed {
        logic [COUNT_W-1:0]             count;
        glyph_t [MAX_GLYPHS-1:0]        codes;
    } strip_desc_t;

    typedef logic [0:GLYPH_ROWS-1][2:0] glyph_rows_t;

    // Reverse three bits so the leftmost glyph pixel lands on the lowest column
    localparam logic [2:0] FLIP3 [0:7] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    // 3x5 glyph ROM, top row first, bit 2 leftmost
    function automatic glyph_rows_t glyph_rows(input glyph_t code);
        glyph_rows_t g;
        case (code)
            5'd0:    g = '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            5'd1:    g = '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
            5'd2:    g = '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            5'd3:    g = '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            5'd4:    g = '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            5'd5:    g = '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            5'd6:    g = '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            5'd7:    g = '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
            5'd8:    g = '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            5'd9:    g = '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            G_F:     g = '{3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
            G_A:     g = '{3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
            G_L:     g = '{3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
            G_O:     g = '{3'd2, 3'd5, 3'd5, 3'd5, 3'd2};
            G_N:     g = '{3'd5, 3'd7, 3'd7, 3'd5, 3'd5};
            G_D:     g = '{3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
            G_E:     g = '{3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
            G_DASH:  g = '{3'd0, 3'd0, 3'd7, 3'd0, 3'd0};
            G_PLUS:  g = '{3'd0, 3'd2, 3'd7, 3'd2, 3'd0};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/onr_front.sv
// Front end: accepts requests, converts the amount to digits and picks the glyph sequence
module onr_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [onr_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] amount
    input  logic [onr_pkg::KIND_W-1:0]     s_tuser,   // [2:0] feedback_kind
    output logic                           push_valid,
    input  logic                           push_ready,
    output onr_pkg::strip_desc_t           push_desc
);
    import onr_pkg::*;

    localparam int HUND_PROD_W = 16;
    localparam int HUND_SHIFT  = 12;
    localparam logic [HUND_PROD_W-1:0] HUND_RECIP = 16'd41;
    localparam int TENS_PROD_W = 14;
    localparam int TENS_SHIFT  = 10;
    localparam logic [TENS_PROD_W-1:0] TENS_RECIP = 14'd103;
    localparam int REM_W       = 7;
    localparam int DIGIT_W     = 4;

    logic                    v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic                    adv1, adv2, adv3, s_accept;
    logic [AMT_W-1:0]        amt_sat;
    logic [AMT_W-1:0]        amt1_reg, amt2_reg;
    logic [KIND_W-1:0]       kind1_reg, kind2_reg, kind3_reg;
    logic [HUND_PROD_W-1:0]  hund_prod;
    logic [DIGIT_W-1:0]      hund2_reg, hund3_reg;
    logic [AMT_W:0]          hund_x100, rem_full;
    logic [REM_W-1:0]        rem3_reg;
    logic [TENS_PROD_W-1:0]  tens_prod;
    logic [DIGIT_W-1:0]      tens, ones;
    logic [REM_W-1:0]        tens_x10, ones_full;
    logic [COUNT_W-1:0]      fill_cnt;

    assign adv3     = v3_reg && push_ready;
    assign adv2     = v2_reg && (!v3_reg || adv3);
    assign adv1     = v1_reg && (!v2_reg || adv2);
    assign s_tready = !v1_reg || adv1;
    assign s_accept = s_tvalid && s_tready;

    assign v1_next = s_accept ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
    assign v2_next = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_reg);
    assign v3_next = adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_reg);

    assign amt_sat = (s_tdata > S_TDATA_W'(AMOUNT_MAX)) ? AMOUNT_MAX : s_tdata[AMT_W-1:0];

    // Hundreds by reciprocal, exact below 1000
    assign hund_prod = HUND_PROD_W'(amt1_reg) * HUND_RECIP;
    assign hund_x100 = (AMT_W + 1)'(hund2_reg) * 11'd100;
    assign rem_full  = (AMT_W + 1)'(amt2_reg) - hund_x100;

    // Tens by reciprocal, exact below 100
    assign tens_prod = TENS_PROD_W'(rem3_reg) * TENS_RECIP;
    assign tens      = tens_prod[TENS_PROD_W-1:TENS_SHIFT];
    assign tens_x10  = REM_W'(tens) * 7'd10;
    assign ones_full = rem3_reg - tens_x10;
    assign ones      = ones_full[DIGIT_W-1:0];

    always_comb begin
        push_desc = '0;
        fill_cnt  = '0;
        case (kind3_reg)
            KIND_MISS: begin
                push_desc.codes[0] = G_F;
                push_desc.codes[1] = G_A;
                push_desc.codes[2] = G_L;
                push_desc.codes[3] = G_L;
                push_desc.codes[4] = G_O;
                fill_cnt           = 3'd5;
            end
            KIND_IMMUNE: begin
                push_desc.codes[0] = G_N;
                push_desc.codes[1] = G_O;
                fill_cnt           = 3'd2;
            end
            KIND_DEFENSE: begin
                push_desc.codes[0] = G_D;
                push_desc.codes[1] = G_E;
                push_desc.codes[2] = G_F;
                push_desc.codes[3] = G_DASH;
                fill_cnt           = 3'd4;
            end
            default: begin
                if (kind3_reg == KIND_HEAL) begin
                    push_desc.codes[fill_cnt] = G_PLUS;
                    fill_cnt = fill_cnt + 3'd1;
                end
                if (hund3_reg != '0) begin
                    push_desc.codes[fill_cnt] = GLYPH_W'(hund3_reg);
                    fill_cnt = fill_cnt + 3'd1;
                end
                if ((hund3_reg != '0) || (rem3_reg >= 7'd10)) begin
                    push_desc.codes[fill_cnt] = GLYPH_W'(tens);
                    fill_cnt = fill_cnt + 3'd1;
                end
                push_desc.codes[fill_cnt] = GLYPH_W'(ones);
                fill_cnt = fill_cnt + 3'd1;
            end
        endcase
        push_desc.count = fill_cnt;
    end

    assign push_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            amt1_reg  <= amt_sat;
            kind1_reg <= s_tuser;
        end
        if (adv1) begin
            amt2_reg  <= amt1_reg;
            hund2_reg <= hund_prod[HUND_PROD_W-1:HUND_SHIFT];
            kind2_reg <= kind1_reg;
        end
        if (adv2) begin
            hund3_reg <= hund2_reg;
            rem3_reg  <= rem_full[REM_W-1:0];
            kind3_reg <= kind2_reg;
        end
    end

endmodule

>>> rtl/core/onr_queue.sv
// Short queue of classified strips between the front end and the renderer
module onr_queue #(
    parameter int DEPTH = onr_pkg::ONR_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  onr_pkg::strip_desc_t  push_desc,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output onr_pkg::strip_desc_t  pop_desc
);
    import onr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    strip_desc_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    assign wr_ptr_next = !do_push ? wr_ptr_reg :
                         (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !do_pop ? rd_ptr_reg :
                         (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/core/onr_back.sv
// Back end: places glyphs into the strip and streams the outlined pixel words
`include "outlined_number_tile_renderer_top_defines.svh"

module onr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  onr_pkg::strip_desc_t           pop_desc,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [onr_pkg::M_TDATA_W-1:0]  m_tdata,   // [1:0] tile_index, [4:2] pixel_row,
                                                      // [36:5] pixel_word, [39:37] zero
    output logic                           m_tlast    // last_word
);
    import onr_pkg::*;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ROWS * 4 - 1);
    localparam logic [TILE_W-1:0] LAST_TILE  = '1;
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [4:0]        CENTRE_COL = 5'd16;
    localparam logic [WORD_W-1:0] NIBBLE_LSB = 32'h1111_1111;

    logic [ROWS-1:0][STRIP_COLS-1:0] rows_reg, rows_next, compose_rows;
    logic                            busy_reg, busy_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [TILE_W-1:0]               tile_reg;
    logic [ROW_W-1:0]                row_reg;
    logic [WORD_W-1:0]               word_reg, word_now;
    logic                            last_reg;
    logic                            issue, last_issue, load;
    logic [4:0]                      left_col;
    logic [STRIP_COLS-1:0]           cur, above, below, outline;
    logic [7:0]                      fg_byte, ol_byte;
    logic [TILE_W-1:0]               tile_now;
    logic [ROW_W-1:0]                row_now;
    logic                            overlap;

    assign issue      = busy_reg && (!m_tvalid_reg || m_tready);
    assign last_issue = issue && (idx_reg == LAST_IDX);
    assign pop_ready  = !busy_reg || last_issue;
    assign load       = pop_valid && pop_ready;

    // Centre n glyphs of width 3 spaced four apart
    assign left_col = CENTRE_COL - {1'b0, pop_desc.count, 1'b0};

    always_comb begin
        glyph_rows_t g;
        logic [4:0]  sh;
        compose_rows = '0;
        for (int i = 0; i < MAX_GLYPHS; i++) begin
            g  = glyph_rows(pop_desc.codes[i]);
            sh = left_col + 5'(i * 4);
            if (COUNT_W'(i) < pop_desc.count) begin
                for (int r = 0; r < GLYPH_ROWS; r++) begin
                    compose_rows[r + GLYPH_TOP] = compose_rows[r + GLYPH_TOP]
                        | (STRIP_COLS'(FLIP3[g[r]]) << sh);
                end
            end
        end
    end

    // Row 0 of the rotating store is the current row, its neighbours sit either side
    assign tile_now = idx_reg[IDX_W-1:ROW_W];
    assign row_now  = idx_reg[ROW_W-1:0];
    assign cur      = rows_reg[0];
    assign above    = (row_now == '0) ? '0 : rows_reg[ROWS-1];
    assign below    = (row_now == LAST_ROW) ? '0 : rows_reg[1];
    assign outline  = ((cur << 1) | (cur >> 1) | above | below) & ~cur;
    assign fg_byte  = cur[{tile_now, 3'b000} +: 8];
    assign ol_byte  = outline[{tile_now, 3'b000} +: 8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            word_now[4*k +: 4] = {2'b00, ol_byte[k], fg_byte[k]};
        end
    end

    always_comb begin
        rows_next = rows_reg;
        if (load) begin
            rows_next = compose_rows;
        end else if (issue) begin
            for (int j = 0; j < ROWS; j++) begin
                rows_next[j] = rows_reg[(j + 1) % ROWS];
            end
        end
    end

    assign busy_next     = load ? 1'b1 : (last_issue ? 1'b0 : busy_reg);
    assign idx_next      = load ? '0 : (issue ? idx_reg + 1'b1 : idx_reg);
    assign m_tvalid_next = issue ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rows_reg <= rows_next;
        if (issue) begin
            tile_reg <= tile_now;
            row_reg  <= row_now;
            word_reg <= word_now;
            last_reg <= idx_reg == LAST_IDX;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {M_PAD_W'(0), word_reg, row_reg, tile_reg};
    assign m_tlast  = last_reg;

    assign overlap = |(word_reg & (word_reg >> 1) & NIBBLE_LSB);

    `ONR_ASSERT_IMPL(a_last_is_final_word, m_tvalid_reg && last_reg, (tile_reg == LAST_TILE) && (row_reg == LAST_ROW), "last word not on final tile row")
    `ONR_ASSERT_IMPL(a_no_glyph_outline_clash, m_tvalid_reg, !overlap, "pixel marked both glyph and outline")
    `ONR_ASSERT_NEXT(a_stay_busy_mid_strip, issue && (idx_reg != LAST_IDX), busy_reg, "strip ended before its last word")

endmodule

>>> rtl/core/outlined_number_tile_renderer_top.sv
// Top level of the outlined number tile renderer
// Each request (amount on s_tdata, feedback kind on s_tuser) renders a 32x8 strip of four
// 8x8 4bpp tiles and leaves as 32 transfers on the m_ side, tile 0 rows 0 to 7 first and
// tile 3 row 7 last with m_tlast set. The row emitter in the back end sends one word per
// cycle while m_tready is high; a request reaches it through the three-stage digit front
// end and the strip loader. The front end and queue hold further requests, so consecutive
// strips stream without a gap while m_tready stays high. Words carry pixel 1 for glyph, 2
// for outline and 0 for empty.
module outlined_number_tile_renderer_top #(
    parameter int QUEUE_DEPTH = onr_pkg::ONR_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [onr_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] amount
    input  logic [onr_pkg::KIND_W-1:0]     s_tuser,   // [2:0] feedback_kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [onr_pkg::M_TDATA_W-1:0]  m_tdata,   // [1:0] tile_index, [4:2] pixel_row,
                                                      // [36:5] pixel_word, [39:37] zero
    output logic                           m_tlast    // last_word
);
    import onr_pkg::*;

    logic        push_valid, push_ready, pop_valid, pop_ready;
    strip_desc_t push_desc, pop_desc;

    onr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    onr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    onr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
